>>> hdl/feature_ratio_classifier_macros.svh
// Assertion macros for the feature ratio classifier checker
`ifndef FEATURE_RATIO_CLASSIFIER_MACROS_SVH
`define FEATURE_RATIO_CLASSIFIER_MACROS_SVH
// implication checked on every clock edge outside reset
`define FRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frc check failed");
// next-cycle implication
`define FRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frc check failed");
`endif

>>> hdl/frc_pkg.sv
//------------------------------------------------------------------------------
// frc_pkg
// Shared types and constants of the feature ratio classifier.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package frc_pkg;
    localparam int unsigned ID_W   = 64;
    localparam int unsigned OCC_W  = 24;
    localparam int unsigned DOCS_W = 24;
    localparam int unsigned PROD_W = 48;
    localparam int unsigned SUM_W  = 64;
    localparam int unsigned CNT_W  = 32;

    typedef enum logic [2:0] {
        REQ_LOAD_M = 3'd0,
        REQ_LOAD_C = 3'd1,
        REQ_TEST   = 3'd2,
        REQ_FINISH = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        VERDICT_UNKNOWN = 2'd0,
        VERDICT_CLEAN   = 2'd1,
        VERDICT_MALWARE = 2'd2
    } t_verdict;

    localparam logic CFG_DOCS_M = 1'b0;
    localparam logic CFG_DOCS_C = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load_m;     // write malware table at fill
        logic load_c;
        logic clear;      // fill counts to zero
        logic scan_start; // reset scan pointers / results
        logic scan_step;  // read next entries
        logic mul;        // form num and den
        logic chk;        // extreme test
        logic div_start;
        logic div_step;
        logic accum;      // add result to sum
        logic finish;     // compute verdict and clear accumulators
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic extreme;    // ratio passes test (also set when infinite)
        logic infinite;   // den zero, num nonzero
        logic q_big;      // integer part saturates
    } t_sts;
endpackage

>>> hdl/frc_ctrl.sv
//------------------------------------------------------------------------------
// frc_ctrl
// Sequencer: accepts a beat, steps the datapath, offers the finish result.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module frc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output frc_pkg::t_cmd     o_cmd,
    input  frc_pkg::t_sts     i_sts
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_MUL, S_CHK, S_DIV, S_ACC, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   acc;

    assign o_ready     = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign acc         = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_req)
                        frc_pkg::REQ_LOAD_M: o_cmd.load_m = 1'b1;
                        frc_pkg::REQ_LOAD_C: o_cmd.load_c = 1'b1;
                        frc_pkg::REQ_CLEAR:  o_cmd.clear  = 1'b1;
                        frc_pkg::REQ_TEST: begin
                            o_cmd.scan_start = 1'b1;
                            n_state = S_SCAN;
                        end
                        frc_pkg::REQ_FINISH: begin
                            o_cmd.finish = 1'b1;
                            n_out_valid  = 1'b1;
                            n_state      = S_OUT;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_MUL;
                else o_cmd.scan_step = 1'b1;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.extreme && !i_sts.infinite) begin
                    o_cmd.div_start = 1'b1;
                    n_state = i_sts.q_big ? S_ACC : S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_ACC;
                else o_cmd.div_step = 1'b1;
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                n_state     = S_IDLE;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

>>> hdl/frc_dpath.sv
//------------------------------------------------------------------------------
// frc_dpath
// Tables, scan, products, restoring divider, accumulators and verdict.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module frc_dpath #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [frc_pkg::DOCS_W-1:0]  i_cfg_data,
    input  logic [frc_pkg::ID_W-1:0]    i_id,
    input  logic [frc_pkg::OCC_W-1:0]   i_occ,
    input  frc_pkg::t_cmd               i_cmd,
    output frc_pkg::t_sts               o_sts,
    output logic [1:0]                  o_verdict,
    output logic [frc_pkg::CNT_W-1:0]   o_count
);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned FW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned PW = frc_pkg::PROD_W;
    localparam int unsigned SW = frc_pkg::SUM_W;
    localparam int unsigned CW = frc_pkg::CNT_W;
    localparam logic [FW-1:0] DEPTH_F = FW'(TABLE_DEPTH);
    localparam logic [SW-1:0] Q_MAX   = {{(SW-PW){1'b0}}, {PW{1'b1}}};

    logic [frc_pkg::ID_W-1:0]  m_ids [TABLE_DEPTH];
    logic [frc_pkg::OCC_W-1:0] m_cnt [TABLE_DEPTH];
    logic [frc_pkg::ID_W-1:0]  c_ids [TABLE_DEPTH];
    logic [frc_pkg::OCC_W-1:0] c_cnt [TABLE_DEPTH];

    logic [frc_pkg::DOCS_W-1:0] r_docs_m, r_docs_c;
    logic [FW-1:0] r_fill_m, r_fill_c;
    logic [frc_pkg::ID_W-1:0] r_key;
    logic [FW-1:0] r_ptr;            // read address issued
    logic          r_rd_v;           // read data valid for r_ptr-1
    logic [FW-1:0] r_rd_idx;
    logic [frc_pkg::ID_W-1:0]  r_mid, r_cid;
    logic [frc_pkg::OCC_W-1:0] r_mocc, r_cocc;
    logic r_mfound, r_cfound;
    logic [frc_pkg::OCC_W-1:0] r_om, r_oc;
    logic [PW-1:0] r_num, r_den;
    logic [PW-1:0] r_rem;
    logic [PW-1:0] r_dvd;            // dividend bits still to shift in
    logic [SW-1:0] r_fx;
    logic [5:0]    r_bit;
    logic [SW-1:0] r_sum;
    logic [CW-1:0] r_cnt;
    logic          r_infseen;
    logic [1:0]    r_verdict;
    logic [CW-1:0] r_outcnt;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_docs_m <= frc_pkg::DOCS_W'(1);
            r_docs_c <= frc_pkg::DOCS_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == frc_pkg::CFG_DOCS_M) r_docs_m <= i_cfg_data;
            else r_docs_c <= i_cfg_data;
        end
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_m && r_fill_m < DEPTH_F) begin
            m_ids[r_fill_m[AW-1:0]] <= i_id;
            m_cnt[r_fill_m[AW-1:0]] <= i_occ;
        end
        if (i_cmd.load_c && r_fill_c < DEPTH_F) begin
            c_ids[r_fill_c[AW-1:0]] <= i_id;
            c_cnt[r_fill_c[AW-1:0]] <= i_occ;
        end
        if (i_cmd.scan_step) begin
            r_mid  <= m_ids[r_ptr[AW-1:0]];
            r_mocc <= m_cnt[r_ptr[AW-1:0]];
            r_cid  <= c_ids[r_ptr[AW-1:0]];
            r_cocc <= c_cnt[r_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_m <= '0;
            r_fill_c <= '0;
        end else if (i_cmd.clear) begin
            r_fill_m <= '0;
            r_fill_c <= '0;
        end else begin
            if (i_cmd.load_m && r_fill_m < DEPTH_F) r_fill_m <= r_fill_m + FW'(1);
            if (i_cmd.load_c && r_fill_c < DEPTH_F) r_fill_c <= r_fill_c + FW'(1);
        end
    end

    // scan: one entry of each table per cycle, compare on registered data
    logic scan_all;
    assign scan_all = (r_ptr >= r_fill_m) && (r_ptr >= r_fill_c);
    assign o_sts.scan_done = scan_all && !r_rd_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_rd_v <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_rd_v <= !scan_all;
        end else begin
            r_rd_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_key    <= i_id;
            r_ptr    <= '0;
            r_mfound <= 1'b0;
            r_cfound <= 1'b0;
            r_om     <= frc_pkg::OCC_W'(1);
            r_oc     <= frc_pkg::OCC_W'(1);
        end else if (i_cmd.scan_step) begin
            if (!scan_all) r_ptr <= r_ptr + FW'(1);
            r_rd_idx <= r_ptr;
            if (r_rd_v) begin
                if (!r_mfound && r_rd_idx < r_fill_m && r_mid == r_key) begin
                    r_mfound <= 1'b1;
                    r_om     <= r_mocc;
                end
                if (!r_cfound && r_rd_idx < r_fill_c && r_cid == r_key) begin
                    r_cfound <= 1'b1;
                    r_oc     <= r_cocc;
                end
            end
        end
    end

    // products, then extreme test
    logic [PW+10-1:0] num_k, den_h;
    assign num_k = (PW+10)'(r_num) * (PW+10)'(1000);
    assign den_h = (PW+10)'(r_den) * (PW+10)'(100);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_num <= PW'(r_om * r_docs_c);
            r_den <= PW'(r_oc * r_docs_m);
        end
    end

    logic chk_inf, chk_ext;
    assign chk_inf = (r_den == '0) && (r_num != '0);
    assign chk_ext = (r_den == '0) ? (r_num != '0)
                   : ((num_k < (PW+10)'(r_den)) || ((PW+10)'(r_num) > den_h));
    assign o_sts.infinite = chk_inf;
    assign o_sts.extreme  = chk_ext;
    // quotient >= 2^24 iff num >= den << 24
    logic [PW+24-1:0] den_sh;
    assign den_sh = {r_den, 24'd0};
    assign o_sts.q_big = ((PW+24)'(r_num) >= den_sh);

    // restoring divider on num*2^24, one quotient bit per cycle. With the
    // quotient below 2^24 the top half of num is already below den, so it
    // seeds the remainder; the low half and 24 zeros follow: 48 steps.
    logic [PW:0] rem2;
    assign rem2 = {r_rem, r_dvd[PW-1]};
    assign o_sts.div_done = (r_bit == 6'd0);
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= {24'd0, r_num[PW-1:24]};
            r_dvd <= {r_num[23:0], 24'd0};
            r_fx  <= o_sts.q_big ? Q_MAX : '0;
            r_bit <= 6'd48;
        end else if (i_cmd.div_step) begin
            if (rem2 >= {1'b0, r_den}) begin
                r_rem <= PW'(rem2 - {1'b0, r_den});
                r_fx  <= {r_fx[SW-2:0], 1'b1};
            end else begin
                r_rem <= PW'(rem2);
                r_fx  <= {r_fx[SW-2:0], 1'b0};
            end
            r_dvd <= {r_dvd[PW-2:0], 1'b0};
            r_bit <= r_bit - 6'd1;
        end
    end

    // accumulators and verdict
    logic [SW:0] sum_add;
    logic [SW+3-1:0] sum5, scaled5;
    logic [SW-1:0] scaled;
    assign sum_add = {1'b0, r_sum} + {1'b0, r_fx};
    assign scaled  = {8'd0, r_cnt, 24'd0};
    assign sum5    = (SW+3)'(r_sum) * (SW+3)'(5);
    assign scaled5 = (SW+3)'(scaled) * (SW+3)'(5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_cnt     <= '0;
            r_infseen <= 1'b0;
        end else if (i_cmd.finish) begin
            r_sum     <= '0;
            r_cnt     <= '0;
            r_infseen <= 1'b0;
        end else begin
            if (i_cmd.chk && chk_ext && r_cnt != '1) r_cnt <= r_cnt + CW'(1);
            if (i_cmd.chk && chk_inf) r_infseen <= 1'b1;
            if (i_cmd.accum) r_sum <= sum_add[SW] ? '1 : sum_add[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_outcnt <= r_cnt;
            if (r_cnt == '0) r_verdict <= frc_pkg::VERDICT_UNKNOWN;
            else if (r_infseen) r_verdict <= frc_pkg::VERDICT_MALWARE;
            else if (r_sum == '0) r_verdict <= frc_pkg::VERDICT_UNKNOWN;
            else if (sum5 < (SW+3)'(scaled)) r_verdict <= frc_pkg::VERDICT_CLEAN;
            else if ((SW+3)'(r_sum) > scaled5) r_verdict <= frc_pkg::VERDICT_MALWARE;
            else r_verdict <= frc_pkg::VERDICT_UNKNOWN;
        end
    end

    assign o_verdict = r_verdict;
    assign o_count   = r_outcnt;
endmodule

>>> hdl/feature_ratio_classifier.sv
//------------------------------------------------------------------------------
// feature_ratio_classifier
// Likelihood-ratio classifier over a malware and a clean feature table.
//------------------------------------------------------------------------------
// channel   | direction | beat contents
// s_axis    | in        | tdata: feature_id[63:0], occurrences[87:64]; tuser: req_type
// m_axis    | out       | tdata: verdict[1:0], counted_features[33:2]
// cfg       | in        | i_cfg_we, i_cfg_idx (0 malware docs, 1 clean docs), i_cfg_data
//
// Load, clear and unused beats are taken straight from idle. A test beat scans
// both tables together, one entry of each a cycle up to the larger fill, then
// forms the products and runs the test; an extreme finite ratio then goes
// through the bit-serial divider (48 steps), skipped when the quotient saturates,
// and is added. The scan length is set by the single table read port.
// A finish beat holds its result in the output register until taken; no new
// beat is accepted meanwhile. Reset (synchronous, active low) clears fills
// and accumulators; the tables themselves are not cleared.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module feature_ratio_classifier #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [87:0]  s_axis_tdata,  // feature_id, occurrences
    input  logic [2:0]   s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // verdict, counted_features
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [23:0]  i_cfg_data
);
    frc_pkg::t_cmd cmd;
    frc_pkg::t_sts sts;
    logic [1:0]  verdict;
    logic [31:0] cnt;

    frc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_req(s_axis_tuser),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(cmd), .i_sts(sts)
    );

    frc_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_id(s_axis_tdata[63:0]), .i_occ(s_axis_tdata[87:64]),
        .i_cmd(cmd), .o_sts(sts),
        .o_verdict(verdict), .o_count(cnt)
    );

    assign m_axis_tdata = {6'd0, cnt, verdict};
endmodule

>>> hdl/frc_checker.sv
//------------------------------------------------------------------------------
// frc_checker
// Port-level checks of the feature ratio classifier.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "feature_ratio_classifier_macros.svh"
module frc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    `FRC_ASSERT_NXT(a_finish_out, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == frc_pkg::REQ_FINISH, m_axis_tvalid)
    `FRC_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `FRC_ASSERT_IMP(a_verdict_ok, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
    `FRC_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind feature_ratio_classifier frc_checker u_frc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

>>> tb/sv/tb_feature_ratio_classifier.sv
//------------------------------------------------------------------------------
// tb_feature_ratio_classifier
// Self-checking bench for the feature ratio classifier: loads feature tables,
// streams test and finish beats, predicts each verdict and feature count.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_feature_ratio_classifier;
    localparam int unsigned DEPTH = 1024;
    localparam int unsigned STALL_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 3000;
    localparam logic [63:0] Q_SAT = (64'd1 << 48) - 64'd1;
    // request codes with no function
    localparam logic [2:0] REQ_SPARE_LO  = 3'd5;
    localparam logic [2:0] REQ_SPARE_MID = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI  = 3'd7;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_idx = 1'b0;
    logic [23:0]  i_cfg_data = '0;

    feature_ratio_classifier #(.TABLE_DEPTH(DEPTH)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct packed {
        frc_pkg::t_verdict verdict;
        logic [31:0]       counted;
    } t_outcome;

    // predictor state
    logic [63:0] mal_id [DEPTH];
    logic [23:0] mal_occ [DEPTH];
    logic [63:0] cln_id [DEPTH];
    logic [23:0] cln_occ [DEPTH];
    int unsigned mal_fill, cln_fill;
    logic [63:0] sum_q;
    logic [31:0] n_extreme;
    logic        inf_flag;
    logic [23:0] docs_m, docs_c;

    t_outcome    verdict_q[$];
    int unsigned n_mismatch = 0;
    int unsigned idle_cycles = 0;
    bit          sink_jitter = 1'b0;
    bit          src_jitter = 1'b0;
    int unsigned hold_off = 0;
    int unsigned hold_req = 0;    // bumped by a test to start a hold-off
    int unsigned hold_seen = 0;
    logic [63:0] pool [16];   // ids used in tables and tests

    // occurrence count of an id: first match, absent counts as one
    function automatic logic [23:0] occ_of(input bit mal, input logic [63:0] id);
        int unsigned n;
        n = mal ? mal_fill : cln_fill;
        for (int unsigned i = 0; i < n; i++) begin
            if (mal ? (mal_id[i] == id) : (cln_id[i] == id))
                return mal ? mal_occ[i] : cln_occ[i];
        end
        return 24'd1;
    endfunction

    task automatic score_feature(input logic [63:0] id);
        logic [47:0] num, den;
        logic [63:0] fx;
        logic [63:0] q;
        num = occ_of(1'b1, id) * docs_c;
        den = occ_of(1'b0, id) * docs_m;
        if (den == 0) begin
            if (num != 0) begin
                inf_flag = 1'b1;
                if (n_extreme != 32'hFFFF_FFFF) n_extreme++;
            end
            return;
        end
        if (!((64'(num) * 1000 < 64'(den)) || (64'(num) > 64'(den) * 100))) return;
        if (n_extreme != 32'hFFFF_FFFF) n_extreme++;
        q = 64'(num) / 64'(den);
        if (q >= (64'd1 << 24)) fx = Q_SAT;
        else fx = 64'((88'(num) << 24) / 88'(den));
        if (sum_q > 64'hFFFF_FFFF_FFFF_FFFF - fx) sum_q = 64'hFFFF_FFFF_FFFF_FFFF;
        else sum_q += fx;
    endtask

    function automatic frc_pkg::t_verdict judge();
        logic [63:0] scaled;
        if (n_extreme == 0) return frc_pkg::VERDICT_UNKNOWN;
        if (inf_flag) return frc_pkg::VERDICT_MALWARE;
        if (sum_q == 0) return frc_pkg::VERDICT_UNKNOWN;
        scaled = 64'(n_extreme) << 24;
        if (sum_q < (64'd1 << 56) && sum_q * 5 < scaled) return frc_pkg::VERDICT_CLEAN;
        if (sum_q > scaled * 5) return frc_pkg::VERDICT_MALWARE;
        return frc_pkg::VERDICT_UNKNOWN;
    endfunction

    task automatic predict(input frc_pkg::t_req req, input logic [63:0] id,
                           input logic [23:0] occ);
        t_outcome o;
        case (req)
            frc_pkg::REQ_LOAD_M: begin
                if (mal_fill < DEPTH) begin
                    mal_id[mal_fill] = id; mal_occ[mal_fill] = occ; mal_fill++;
                end
            end
            frc_pkg::REQ_LOAD_C: begin
                if (cln_fill < DEPTH) begin
                    cln_id[cln_fill] = id; cln_occ[cln_fill] = occ; cln_fill++;
                end
            end
            frc_pkg::REQ_TEST: score_feature(id);
            frc_pkg::REQ_FINISH: begin
                o.verdict = judge();
                o.counted = n_extreme;
                verdict_q.push_back(o);
                sum_q = '0; n_extreme = '0; inf_flag = 1'b0;
            end
            frc_pkg::REQ_CLEAR: begin
                mal_fill = 0; cln_fill = 0;
            end
            default: ;
        endcase
    endtask

    // one beat; optional random gap before it when jitter is on. tvalid stays
    // up after the beat and is dropped by a gap, a drain or a register write.
    task automatic send_beat(input logic [2:0] req, input logic [63:0] id,
                             input logic [23:0] occ);
        if (src_jitter && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {occ, id};
        do @(posedge i_clk); while (!s_axis_tready);
        predict(frc_pkg::t_req'(req), id, occ);
    endtask

    task automatic write_reg(input logic idx, input logic [23:0] val);
        s_axis_tvalid <= 1'b0;
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == frc_pkg::CFG_DOCS_M) docs_m = val; else docs_c = val;
        @(posedge i_clk);
    endtask

    // wait for all finishes, then let a table scan drain before touching config
    task automatic drain();
        int unsigned guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0 && guard < STALL_LIMIT) begin
            @(posedge i_clk); guard++;
        end
        repeat (DEPTH + 80) @(posedge i_clk);
    endtask

    // output side: random stall bursts, plus the long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_off <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_off != 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_jitter && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected beat %h", m_axis_tdata);
            end else begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[1:0] !== want.verdict
                        || m_axis_tdata[33:2] !== want.counted) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("verdict exp %0d/%0d got %0d/%0d", want.verdict,
                                 want.counted, m_axis_tdata[1:0], m_axis_tdata[33:2]);
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_id();
        return pool[$urandom_range(0, 15)];
    endfunction

    //--------------------------------------------------------------------------
    // directed: extreme ids and counts, every request, zero docs, unused codes
    task automatic test_directed();
        send_beat(frc_pkg::REQ_FINISH, '0, '0);       // empty: unknown, count 0
        send_beat(frc_pkg::REQ_LOAD_M, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF);
        send_beat(frc_pkg::REQ_LOAD_M, 64'h0, 24'd0);
        send_beat(frc_pkg::REQ_LOAD_C, 64'h0, 24'd0);
        send_beat(frc_pkg::REQ_LOAD_C, 64'hFFFF_FFFF_FFFF_FFFF, 24'd1);
        send_beat(frc_pkg::REQ_LOAD_M, 64'h0, 24'd5); // duplicate, not first
        send_beat(frc_pkg::REQ_TEST, 64'hFFFF_FFFF_FFFF_FFFF, '0);  // large ratio, just below saturation
        send_beat(frc_pkg::REQ_FINISH, '0, '0);
        send_beat(frc_pkg::REQ_TEST, 64'h0, 24'hFFFFFF);   // 0/0: ignored
        send_beat(frc_pkg::REQ_TEST, 64'h1234, '0);        // absent both: ratio 1
        send_beat(frc_pkg::REQ_FINISH, '0, '0);
        send_beat(frc_pkg::REQ_LOAD_C, 64'h55, 24'd20000); // tiny ratio: clean
        send_beat(frc_pkg::REQ_TEST, 64'h55, '0);
        send_beat(frc_pkg::REQ_FINISH, '0, '0);
        send_beat(REQ_SPARE_LO, rand64(), 24'hABCDEF);
        send_beat(REQ_SPARE_MID, '0, '0);
        send_beat(REQ_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF);
        send_beat(frc_pkg::REQ_LOAD_C, 64'h77, 24'd0);     // clean zero
        send_beat(frc_pkg::REQ_TEST, 64'h77, '0);          // infinite flag
        send_beat(frc_pkg::REQ_FINISH, '0, '0);
        send_beat(frc_pkg::REQ_CLEAR, '0, '0);
        send_beat(frc_pkg::REQ_TEST, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        send_beat(frc_pkg::REQ_FINISH, '0, '0);
        drain();
        // zero document counts: undefined ratios are ignored
        write_reg(frc_pkg::CFG_DOCS_M, 24'd0);
        write_reg(frc_pkg::CFG_DOCS_C, 24'd0);
        send_beat(frc_pkg::REQ_TEST, 64'h5, '0);
        send_beat(frc_pkg::REQ_FINISH, '0, '0);
        drain();
    endtask

    // well-formed sessions: tables, a run of tests, a finish
    task automatic run_sessions(input int unsigned n_beats);
        int unsigned sent;
        int unsigned k;
        sent = 0;
        while (sent < n_beats) begin
            if ($urandom_range(0, 3) == 0) begin
                send_beat(frc_pkg::REQ_CLEAR, rand64(), 24'($urandom())); sent++;
            end
            k = $urandom_range(1, 8);
            repeat (k) begin
                send_beat($urandom_range(0, 1) ? frc_pkg::REQ_LOAD_M : frc_pkg::REQ_LOAD_C,
                          $urandom_range(0, 7) == 0 ? rand64() : pick_id(),
                          $urandom_range(0, 3) == 0 ? 24'($urandom())
                                                    : 24'($urandom_range(0, 300)));
                sent++;
            end
            k = $urandom_range(1, 8);
            repeat (k) begin
                send_beat($urandom_range(0, 15) == 0
                              ? REQ_SPARE_LO + 3'($urandom_range(0, 2))
                              : frc_pkg::REQ_TEST,
                          $urandom_range(0, 5) == 0 ? rand64() : pick_id(),
                          24'($urandom()));
                sent++;
            end
            send_beat(frc_pkg::REQ_FINISH, rand64(), 24'($urandom())); sent++;
        end
    endtask

    task automatic test_settings();
        logic [23:0] vals [6];
        vals = '{24'd1, 24'hFFFFFF, 24'd1000, 24'd3, 24'd200000, 24'd1};
        for (int i = 0; i < 3; i++) begin
            write_reg(frc_pkg::CFG_DOCS_M, vals[2*i]);
            write_reg(frc_pkg::CFG_DOCS_C, vals[2*i+1]);
            run_sessions(90);
            drain();
        end
        write_reg(frc_pkg::CFG_DOCS_M, 24'($urandom_range(1, 24'hFFFFFF)));
        write_reg(frc_pkg::CFG_DOCS_C, 24'($urandom_range(1, 50)));
        run_sessions(90);
        drain();
    endtask

    // receiver holds off long while finishes pile up behind the output register
    task automatic test_backpressure();
        hold_req++;
        repeat (30) send_beat(frc_pkg::REQ_FINISH, '0, '0);
        drain();                       // sender pauses until all are in
    endtask

    initial begin
        mal_fill = 0; cln_fill = 0; sum_q = '0; n_extreme = '0; inf_flag = 1'b0;
        docs_m = 24'd1; docs_c = 24'd1;
        for (int i = 0; i < 16; i++) pool[i] = (i < 2) ? 64'(i) : rand64();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        write_reg(frc_pkg::CFG_DOCS_M, 24'd1);
        write_reg(frc_pkg::CFG_DOCS_C, 24'd1);
        src_jitter = 1'b1; sink_jitter = 1'b1;
        test_settings();
        test_backpressure();
        src_jitter = 1'b0; sink_jitter = 1'b0;   // no idling in the tail
        run_sessions(90);
        drain();
        if (n_mismatch == 0 && verdict_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
